// ----- sv/e2r_pkg.sv -----
// Package for the Euler-angle to rotation-matrix block.
// Holds the CORDIC arctangent table and shared fixed-point widths.
// No dependencies.
package e2r_pkg;

   localparam int WORK_BITS  = 30;
   localparam int ITERATIONS = 30;
   // Q30 carried in 34 bits; CORDIC x/y stay well inside this.
   localparam int VAL_BITS   = 34;
   localparam int ZB         = 33;
   localparam int IDX_BITS   = 5;
   localparam logic signed [VAL_BITS-1:0] CORDIC_X0 = 34'sd652032874;
   localparam logic signed [VAL_BITS-1:0] ONE_Q30   = 34'sd1073741824;

   typedef logic signed [VAL_BITS-1:0] val_type;
   typedef logic signed [ZB-1:0]       ang_type;
   typedef logic [1:0]                 quad_type;

   // One CORDIC cell's data for one angle
   typedef struct packed {
      val_type  x;
      val_type  y;
      ang_type  z;
      quad_type q;
   } rot_type;

   // Arctangent of 2^-i, 2^32 per turn
   function automatic ang_type arc_lookup(input logic [IDX_BITS-1:0] i);
      ang_type r;
      r = '0;
      unique case (i)
         5'd0:  r = 33'h020000000;
         5'd1:  r = 33'h012E4051E;
         5'd2:  r = 33'h009FB385B;
         5'd3:  r = 33'h0051111D4;
         5'd4:  r = 33'h0028B0D43;
         5'd5:  r = 33'h00145D7E1;
         5'd6:  r = 33'h000A2F61E;
         5'd7:  r = 33'h000517C55;
         5'd8:  r = 33'h00028BE53;
         5'd9:  r = 33'h000145F2F;
         5'd10: r = 33'h0000A2F98;
         5'd11: r = 33'h0000517CC;
         5'd12: r = 33'h000028BE6;
         5'd13: r = 33'h0000145F3;
         5'd14: r = 33'h00000A2F9;
         5'd15: r = 33'h00000517C;
         5'd16: r = 33'h0000028BE;
         5'd17: r = 33'h00000145F;
         5'd18: r = 33'h000000A2F;
         5'd19: r = 33'h000000517;
         5'd20: r = 33'h00000028B;
         5'd21: r = 33'h000000145;
         5'd22: r = 33'h0000000A2;
         5'd23: r = 33'h000000051;
         5'd24: r = 33'h000000028;
         5'd25: r = 33'h000000014;
         5'd26: r = 33'h00000000A;
         5'd27: r = 33'h000000005;
         5'd28: r = 33'h000000002;
         5'd29: r = 33'h000000001;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Q30 product with round-half-up: floor((a*b + 2^29) / 2^30)
   function automatic val_type mul_q30(input val_type a, input val_type b);
      logic signed [2*VAL_BITS-1:0] p;
      p = (2*VAL_BITS)'(a) * (2*VAL_BITS)'(b) + (2*VAL_BITS)'(64'sd536870912);
      return VAL_BITS'(p >>> WORK_BITS);
   endfunction

endpackage

// ----- sv/e2r_cell.sv -----
// One CORDIC micro-rotation cell: rotates three angles by one step.
// Depends on e2r_pkg.
module e2r_cell #(
   parameter int STEP = 0
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            vld_in,
   input  e2r_pkg::rot_type rot_in [3],
   output logic            vld_out,
   output e2r_pkg::rot_type rot_out [3]
);
   import e2r_pkg::*;

   localparam logic [IDX_BITS-1:0] IDX = IDX_BITS'(STEP);

   logic    vld_ff;
   rot_type rot_ff [3];
   rot_type rot_nx [3];
   ang_type arc;

   assign arc = arc_lookup(IDX);

   // Shift-add rotation, direction from residual sign
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rot_nx[k].q = rot_in[k].q;
         if (!rot_in[k].z[ZB-1]) begin
            rot_nx[k].x = rot_in[k].x - (rot_in[k].y >>> STEP);
            rot_nx[k].y = rot_in[k].y + (rot_in[k].x >>> STEP);
            rot_nx[k].z = rot_in[k].z - arc;
         end else begin
            rot_nx[k].x = rot_in[k].x + (rot_in[k].y >>> STEP);
            rot_nx[k].y = rot_in[k].y - (rot_in[k].x >>> STEP);
            rot_nx[k].z = rot_in[k].z + arc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else       vld_ff <= vld_in;
      rot_ff <= rot_nx;
   end

   assign vld_out = vld_ff;
   assign rot_out = rot_ff;
endmodule

// ----- sv/e2r_combine.sv -----
// Quadrant fix-up and matrix products, pipelined with at most one level of multiplies per stage.
// Depends on e2r_pkg.
module e2r_combine #(
   parameter int FRACTION_BITS = 14
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             vld_in,
   input  e2r_pkg::rot_type rot_in [3],
   output logic             vld_out,
   output logic signed [FRACTION_BITS+1:0] ent_out [9]
);
   import e2r_pkg::*;

   localparam int OW = FRACTION_BITS + 2;
   localparam int SH = WORK_BITS - FRACTION_BITS;
   localparam val_type HALF = val_type'(64'sd1 <<< (SH - 1));
   localparam val_type LIM  = val_type'(64'sd1 <<< FRACTION_BITS);

   logic [3:0] vld_ff;
   val_type    c_in [3];
   val_type    s_in [3];
   val_type    c_ff [3];
   val_type    s_ff [3];
   val_type    p_ff [9];  // first-level products
   val_type    ct2_ff;
   // sines/cosines delayed to line up with the first-level products
   val_type    cs2_ff;
   val_type    ss2_ff;
   val_type    st2_ff;
   val_type    ch2_ff;
   val_type    sum_in [9];
   val_type    sum_ff [9];
   logic signed [OW-1:0] ent_in [9];
   logic signed [OW-1:0] ent_ff [9];

   function automatic val_type clamp1(input val_type v);
      if (v > ONE_Q30)       return ONE_Q30;
      else if (v < -ONE_Q30) return -ONE_Q30;
      else                   return v;
   endfunction

   // Map CORDIC output by quadrant, clamp to one
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         unique case (rot_in[k].q)
            2'd0: begin c_in[k] = rot_in[k].x;  s_in[k] = rot_in[k].y;  end
            2'd1: begin c_in[k] = -rot_in[k].y; s_in[k] = rot_in[k].x;  end
            2'd2: begin c_in[k] = -rot_in[k].x; s_in[k] = -rot_in[k].y; end
            default: begin c_in[k] = rot_in[k].y; s_in[k] = -rot_in[k].x; end
         endcase
         c_in[k] = clamp1(c_in[k]);
         s_in[k] = clamp1(s_in[k]);
      end
   end

   // index 0 phi(h), 1 theta(t), 2 psi(s)
   // Sums from second-level products
   always_comb begin
      sum_in[0] = p_ff[0] - mul_q30(p_ff[4], ss2_ff);
      sum_in[1] = p_ff[1] + mul_q30(p_ff[5], ss2_ff);
      sum_in[2] = p_ff[2];
      sum_in[3] = -p_ff[3] - mul_q30(p_ff[4], cs2_ff);
      sum_in[4] = -p_ff[6] + mul_q30(p_ff[5], cs2_ff);
      sum_in[5] = p_ff[7];
      sum_in[6] = p_ff[8];
      sum_in[7] = -mul_q30(st2_ff, ch2_ff);
      sum_in[8] = ct2_ff;
   end

   // Round to output precision and saturate
   always_comb begin
      val_type r;
      for (int k = 0; k < 9; k++) begin
         r = (sum_ff[k] + HALF) >>> SH;
         if (r > LIM)       r = LIM;
         else if (r < -LIM) r = -LIM;
         ent_in[k] = OW'(r);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= {vld_ff[2:0], vld_in};
      c_ff <= c_in;
      s_ff <= s_in;
      p_ff[0] <= mul_q30(c_ff[2], c_ff[0]);
      p_ff[1] <= mul_q30(c_ff[2], s_ff[0]);
      p_ff[2] <= mul_q30(s_ff[2], s_ff[1]);
      p_ff[3] <= mul_q30(s_ff[2], c_ff[0]);
      p_ff[4] <= mul_q30(c_ff[1], s_ff[0]);
      p_ff[5] <= mul_q30(c_ff[1], c_ff[0]);
      p_ff[6] <= mul_q30(s_ff[2], s_ff[0]);
      p_ff[7] <= mul_q30(c_ff[2], s_ff[1]);
      p_ff[8] <= mul_q30(s_ff[1], s_ff[0]);
      ct2_ff  <= c_ff[1];
      cs2_ff  <= c_ff[2];
      ss2_ff  <= s_ff[2];
      st2_ff  <= s_ff[1];
      ch2_ff  <= c_ff[0];
      sum_ff  <= sum_in;
      ent_ff  <= ent_in;
   end

   assign vld_out = vld_ff[3];
   assign ent_out = ent_ff;
endmodule

// ----- sv/euler_to_rotation_matrix.sv -----
// Top level: Euler z-x-z angles to 3x3 rotation matrix.
// Depends on e2r_pkg, e2r_cell, e2r_combine.
//
//  channel | ports                       | handshake
//  input   | req_phi/theta/psi_angle     | start high, busy low
//  result  | rsp_r_xx .. rsp_r_zz        | rsp_valid strobe, one cycle
//
// One item per cycle; busy is always low. The pipeline is one input
// register, 30 CORDIC cells in a chain and four combine stages (fix-up,
// first products, sums with second products, rounding). Synchronous reset
// clears the valid chain only. The receiver cannot stall results.
module euler_to_rotation_matrix #(
   parameter int ANGLE_BITS    = 16,
   parameter int FRACTION_BITS = 14
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [ANGLE_BITS-1:0] req_phi_angle,
   input  logic signed [ANGLE_BITS-1:0] req_theta_angle,
   input  logic signed [ANGLE_BITS-1:0] req_psi_angle,
   output logic rsp_valid,
   output logic signed [FRACTION_BITS+1:0] rsp_r_xx,
   output logic signed [FRACTION_BITS+1:0] rsp_r_xy,
   output logic signed [FRACTION_BITS+1:0] rsp_r_xz,
   output logic signed [FRACTION_BITS+1:0] rsp_r_yx,
   output logic signed [FRACTION_BITS+1:0] rsp_r_yy,
   output logic signed [FRACTION_BITS+1:0] rsp_r_yz,
   output logic signed [FRACTION_BITS+1:0] rsp_r_zx,
   output logic signed [FRACTION_BITS+1:0] rsp_r_zy,
   output logic signed [FRACTION_BITS+1:0] rsp_r_zz
);
   import e2r_pkg::*;

   logic [31:0] turn [3];
   logic        vld_ff;
   rot_type     rot_in [3];
   rot_type     rot_ff [3];
   logic        vld_c [ITERATIONS+1];
   rot_type     rot_c [ITERATIONS+1][3];
   logic signed [FRACTION_BITS+1:0] ent [9];

   assign busy = 1'b0;

   // Scale to 2^32 per turn and strip the quadrant
   always_comb begin
      logic [31:0] rem;
      logic [1:0]  q;
      turn[0] = 32'({req_phi_angle, 32'd0} >> ANGLE_BITS);
      turn[1] = 32'({req_theta_angle, 32'd0} >> ANGLE_BITS);
      turn[2] = 32'({req_psi_angle, 32'd0} >> ANGLE_BITS);
      for (int k = 0; k < 3; k++) begin
         q   = 2'((turn[k] + 32'h2000_0000) >> 30);
         rem = turn[k] - {q, 30'd0};
         rot_in[k].q = q;
         rot_in[k].z = ang_type'($signed(rem));
         rot_in[k].x = CORDIC_X0;
         rot_in[k].y = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else       vld_ff <= start;
      rot_ff <= rot_in;
   end

   assign vld_c[0] = vld_ff;
   assign rot_c[0] = rot_ff;

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
      e2r_cell #(.STEP(i)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .vld_in (vld_c[i]),
         .rot_in (rot_c[i]),
         .vld_out(vld_c[i+1]),
         .rot_out(rot_c[i+1])
      );
   end

   e2r_combine #(.FRACTION_BITS(FRACTION_BITS)) u_combine (
      .clock  (clock),
      .reset  (reset),
      .vld_in (vld_c[ITERATIONS]),
      .rot_in (rot_c[ITERATIONS]),
      .vld_out(rsp_valid),
      .ent_out(ent)
   );

   assign rsp_r_xx = ent[0];
   assign rsp_r_xy = ent[1];
   assign rsp_r_xz = ent[2];
   assign rsp_r_yx = ent[3];
   assign rsp_r_yy = ent[4];
   assign rsp_r_yz = ent[5];
   assign rsp_r_zx = ent[6];
   assign rsp_r_zy = ent[7];
   assign rsp_r_zz = ent[8];
endmodule
